### src/dccpg_pkg.sv
// ----------------------------------------------------------------------------
// dccpg_pkg
// Shared types and constants of the DCC packet generator: command and symbol
// codes, the cell payload and the frame load bundle.
// ----------------------------------------------------------------------------
package dccpg_pkg;

    localparam int PREAMBLE_LEN_DEF = 16;
    // a start symbol before each of three bytes and the check byte, then end and cutout, or the
    // short layout padded to the same length
    localparam int TAIL_LEN         = 38;

    localparam logic [7:0]  REPEAT_RESET = 8'd3;
    // byte 0 in the lowest bits: FF 00 FF FF
    localparam logic [31:0] IDLE_BYTES   = 32'hFFFF_00FF;
    localparam logic [31:0] RESET_BYTES  = 32'hFF00_0000;

    typedef enum logic [2:0] {
        CMD_SLOT  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_RESET = 3'd3,
        CMD_SHORT = 3'd4,
        CMD_EXT   = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        SYM_ZERO   = 3'd0,
        SYM_ONE    = 3'd1,
        SYM_START  = 3'd2,
        SYM_END    = 3'd3,
        SYM_CUTOUT = 3'd4
    } sym_t;

    typedef struct packed {
        logic        valid;
        sym_t        sym;
        logic        te;
        logic        last;
    } cell_t;

    typedef struct packed {
        logic        load;
        logic [31:0] bytes;
        logic        ext;
        logic        te;
    } load_t;

endpackage

### src/dccpg_cell.sv
// ----------------------------------------------------------------------------
// dccpg_cell
// One symbol position of the frame chain. Loads its own symbol from the
// packet bytes, or takes the symbol of its upstream neighbour on advance.
// ----------------------------------------------------------------------------
module dccpg_cell #(
    parameter int IDX          = 0,
    parameter int PREAMBLE_LEN = dccpg_pkg::PREAMBLE_LEN_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  dccpg_pkg::load_t ld,
    input  logic             advance,
    input  dccpg_pkg::cell_t nbr,
    output dccpg_pkg::cell_t q
);

    localparam int FRAME_LEN = PREAMBLE_LEN + dccpg_pkg::TAIL_LEN;
    localparam int P   = IDX - PREAMBLE_LEN;
    localparam int SEG = (P >= 0) ? P / 9 : 0;
    localparam int BIT = (P >= 0) ? P % 9 : 0;
    localparam int BI  = (P >= 0 && P < 36 && BIT != 0) ? SEG * 8 + 8 - BIT : 0;

    logic             valid_reg, valid_next;
    dccpg_pkg::sym_t  sym_reg, sym_next;
    logic             te_reg, te_next;
    logic             last_reg, last_next;
    dccpg_pkg::sym_t  load_sym;
    logic             short_tail;

    always_comb begin
        short_tail = (SEG == 3) && !ld.ext;
        if (P < 0) begin
            load_sym = dccpg_pkg::SYM_ONE;
        end else if (P < 36) begin
            if (BIT == 0) begin
                load_sym = short_tail ? dccpg_pkg::SYM_END : dccpg_pkg::SYM_START;
            end else if (short_tail) begin
                load_sym = (P == 28) ? dccpg_pkg::SYM_CUTOUT : dccpg_pkg::SYM_ONE;
            end else begin
                load_sym = ld.bytes[BI] ? dccpg_pkg::SYM_ONE : dccpg_pkg::SYM_ZERO;
            end
        end else if (P == 36) begin
            load_sym = dccpg_pkg::SYM_END;
        end else begin
            load_sym = ld.ext ? dccpg_pkg::SYM_CUTOUT : dccpg_pkg::SYM_END;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        sym_next   = sym_reg;
        te_next    = te_reg;
        last_next  = last_reg;
        if (ld.load) begin
            valid_next = 1'b1;
            sym_next   = load_sym;
            te_next    = ld.te;
            last_next  = (IDX == FRAME_LEN - 1);
        end else if (advance) begin
            // take the neighbour's symbol, the far end fills with empty cells
            valid_next = nbr.valid;
            sym_next   = nbr.sym;
            te_next    = nbr.te;
            last_next  = nbr.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        sym_reg  <= sym_next;
        te_reg   <= te_next;
        last_reg <= last_next;
    end

    assign q = '{valid: valid_reg, sym: sym_reg, te: te_reg, last: last_reg};

endmodule

### src/dccpg_ctrl.sv
// ----------------------------------------------------------------------------
// dccpg_ctrl
// Command decoder and packet state: output on/off, work packet, repeats.
// Issues a frame load to the cell chain for every slot item while on.
// ----------------------------------------------------------------------------
module dccpg_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             accept,
    input  logic [2:0]       cmd,
    input  logic [7:0]       address,
    input  logic [7:0]       data0,
    input  logic [7:0]       data1,
    output dccpg_pkg::load_t ld
);

    logic [7:0]  repeat_count_reg, repeat_count_next;
    logic        output_on_reg, output_on_next;
    logic        pending_reg, pending_next;
    logic        ext_reg, ext_next;
    logic [7:0]  repeats_left_reg, repeats_left_next;
    logic [31:0] bytes_reg, bytes_next;
    logic        rearm;

    always_comb begin
        repeat_count_next = cfg_wr_en ? cfg_wr_data : repeat_count_reg;
        output_on_next    = output_on_reg;
        pending_next      = pending_reg;
        ext_next          = ext_reg;
        repeats_left_next = repeats_left_reg;
        bytes_next        = bytes_reg;
        rearm             = 1'b0;

        ld.load  = 1'b0;
        ld.bytes = pending_reg ? bytes_reg : dccpg_pkg::IDLE_BYTES;
        ld.ext   = pending_reg && ext_reg;
        ld.te    = pending_reg;

        if (accept) begin
            unique case (cmd)
                dccpg_pkg::CMD_SLOT: begin
                    if (output_on_reg) begin
                        ld.load = 1'b1;
                        if (pending_reg) begin
                            if (repeats_left_reg != 8'd0) begin
                                repeats_left_next = repeats_left_reg - 8'd1;
                            end else begin
                                pending_next = 1'b0;
                            end
                        end else begin
                            ext_next = 1'b0;
                        end
                    end
                end
                dccpg_pkg::CMD_START: begin
                    output_on_next = 1'b1;
                    rearm          = 1'b1;
                end
                dccpg_pkg::CMD_STOP: begin
                    output_on_next = 1'b0;
                    rearm          = 1'b1;
                end
                dccpg_pkg::CMD_RESET: begin
                    bytes_next = dccpg_pkg::RESET_BYTES;
                    ext_next   = 1'b0;
                    rearm      = 1'b1;
                end
                dccpg_pkg::CMD_SHORT: begin
                    bytes_next = {8'hFF, address ^ data0, data0, address};
                    ext_next   = 1'b0;
                    rearm      = 1'b1;
                end
                dccpg_pkg::CMD_EXT: begin
                    bytes_next = {address ^ data0 ^ data1, data1, data0, address};
                    ext_next   = 1'b1;
                    rearm      = 1'b1;
                end
                default: begin
                    // unused codes: drop
                end
            endcase
        end

        if (rearm) begin
            repeats_left_next = repeat_count_reg;
            pending_next      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_count_reg <= dccpg_pkg::REPEAT_RESET;
            output_on_reg    <= 1'b0;
            pending_reg      <= 1'b0;
            ext_reg          <= 1'b0;
            repeats_left_reg <= 8'd0;
            bytes_reg        <= dccpg_pkg::IDLE_BYTES;
        end else begin
            repeat_count_reg <= repeat_count_next;
            output_on_reg    <= output_on_next;
            pending_reg      <= pending_next;
            ext_reg          <= ext_next;
            repeats_left_reg <= repeats_left_next;
            bytes_reg        <= bytes_next;
        end
    end

endmodule

### src/dcc_packet_generator_unit.sv
// A slot item accepted at one edge shows its first symbol on m_ in the next cycle.
// Throughput: one symbol per cycle while m_tready is high, from a symbol chain of
// PREAMBLE_LEN+38 cells holding one slot frame. Items are taken whenever the chain is
// empty or holds only the final symbol being taken; command items then pass one per cycle.
// Reset (aresetn low, synchronous): chain emptied, output off, idle packet loaded,
// repeat_count back to 3.
// ----------------------------------------------------------------------------
// dcc_packet_generator_unit
// DCC packet encoder: command decoder feeding a chain of symbol cells that
// shifts one line symbol per cycle towards the result channel while m_tready is high.
// ----------------------------------------------------------------------------
module dcc_packet_generator_unit #(
    parameter int PREAMBLE_LEN = dccpg_pkg::PREAMBLE_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // repeat_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // cmd[2:0], address[10:3], data0[18:11], data1[26:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // symbol[2:0], cutout_gate[3], track_enable[4]
    output logic        m_tlast
);

    localparam int FRAME_LEN = PREAMBLE_LEN + dccpg_pkg::TAIL_LEN;

    dccpg_pkg::cell_t chain [FRAME_LEN+1];
    dccpg_pkg::load_t ld;
    logic             advance;
    logic             accept;

    assign advance  = chain[0].valid && m_tready;
    assign s_tready = !chain[0].valid || (!chain[1].valid && m_tready);
    assign accept   = s_tvalid && s_tready;

    assign chain[FRAME_LEN] = '{valid: 1'b0, sym: dccpg_pkg::SYM_ONE, te: 1'b0, last: 1'b0};

    dccpg_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .cmd         (s_tdata[2:0]),
        .address     (s_tdata[10:3]),
        .data0       (s_tdata[18:11]),
        .data1       (s_tdata[26:19]),
        .ld          (ld)
    );

    for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
        dccpg_cell #(
            .IDX          (i),
            .PREAMBLE_LEN (PREAMBLE_LEN)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ld      (ld),
            .advance (advance),
            .nbr     (chain[i+1]),
            .q       (chain[i])
        );
    end

    assign m_tvalid = chain[0].valid;
    assign m_tlast  = chain[0].last;
    assign m_tdata  = {3'b000, chain[0].te, chain[0].sym == dccpg_pkg::SYM_CUTOUT,
                       chain[0].sym};

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ld.load |-> (!chain[0].valid || (!chain[1].valid && m_tready)))
        else $error("frame loaded over symbols still waiting");

    a_last_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain[0].valid && chain[0].last) |-> !chain[1].valid)
        else $error("symbols queued behind the final symbol of a frame");

    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !chain[0].last) |=> m_tvalid)
        else $error("frame broken before its final symbol");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty chain");

endmodule

### verif/dcc_packet_generator_unit_tb.sv
// ----------------------------------------------------------------------------
// dcc_packet_generator_unit_tb
// Self-checking bench for the DCC packet encoder. Command items go in on the
// s_ stream in random bursts while m_ is throttled. Every line symbol is
// checked against a frame builder kept in step with the accepted commands.
// ----------------------------------------------------------------------------
module dcc_packet_generator_unit_tb;

    localparam int PREAMBLE   = dccpg_pkg::PREAMBLE_LEN_DEF;
    localparam int SETTLE     = 16;
    localparam int QUIET_MAX  = 1000;

    // command codes the block must ignore
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    // one command item, cmd in the lowest bits
    typedef struct packed {
        logic [7:0] data1;
        logic [7:0] data0;
        logic [7:0] address;
        logic [2:0] cmd;
    } dcc_cmd_t;

    typedef struct packed {
        dccpg_pkg::sym_t sym;
        logic            gate;
        logic            te;
        logic            last;
    } line_sym_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    dcc_packet_generator_unit #(.PREAMBLE_LEN(PREAMBLE)) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // encoder state as the bench sees it
    logic        gen_on;
    logic        gen_pending;
    logic        gen_ext;
    logic [7:0]  gen_repeats_left;
    logic [7:0]  gen_repeat_count;
    logic [31:0] gen_bytes;

    dcc_cmd_t  cmd_queue[$];
    line_sym_t line_syms_due[$];

    int items_queued = 0;
    int items_taken = 0;
    int mism_count = 0;
    int syms_checked = 0;
    int frames_checked = 0;
    int packet_frames = 0;
    int idle_frames = 0;
    int muted_slots = 0;
    int loads = 0;
    int ignored_cmds = 0;
    int settings_tried = 1;
    int quiet_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_left = 0;
    logic [31:0] rx_cycle = 0;
    logic s_taken = 1'b0;
    logic m_taken = 1'b0;

    task automatic flag_mismatch(input string msg);
        mism_count++;
        $display("[%0t] mismatch %0d: %s", $realtime, mism_count, msg);
    endtask

    // append the symbols of one frame: preamble, bytes MSB first, check, end, cutout
    function automatic void queue_frame(logic [31:0] b, logic ext, logic te);
        dccpg_pkg::sym_t seq[$];
        line_sym_t       rec;
        int              nbytes;
        nbytes = ext ? 4 : 3;
        repeat (PREAMBLE) seq.push_back(dccpg_pkg::SYM_ONE);
        for (int k = 0; k < nbytes; k++) begin
            seq.push_back(dccpg_pkg::SYM_START);
            for (int j = 7; j >= 0; j--)
                seq.push_back(b[8*k+j] ? dccpg_pkg::SYM_ONE : dccpg_pkg::SYM_ZERO);
        end
        seq.push_back(dccpg_pkg::SYM_END);
        seq.push_back(dccpg_pkg::SYM_CUTOUT);
        if (!ext) begin
            // pad the short layout to the common frame length
            repeat (7) seq.push_back(dccpg_pkg::SYM_ONE);
            seq.push_back(dccpg_pkg::SYM_END);
            seq.push_back(dccpg_pkg::SYM_END);
        end
        foreach (seq[i]) begin
            rec.sym  = seq[i];
            rec.gate = (seq[i] == dccpg_pkg::SYM_CUTOUT);
            rec.te   = te;
            rec.last = (i == seq.size() - 1);
            line_syms_due.push_back(rec);
        end
    endfunction

    function automatic void run_command(dcc_cmd_t c);
        logic rearm;
        rearm = 1'b1;
        case (c.cmd)
            dccpg_pkg::CMD_SLOT: begin
                rearm = 1'b0;
                if (!gen_on) begin
                    muted_slots++;
                end else if (gen_pending) begin
                    queue_frame(gen_bytes, gen_ext, 1'b1);
                    packet_frames++;
                    if (gen_repeats_left != 0)
                        gen_repeats_left--;
                    else
                        gen_pending = 1'b0;
                end else begin
                    // first idle frame drops the extended layout
                    gen_ext = 1'b0;
                    queue_frame(dccpg_pkg::IDLE_BYTES, 1'b0, 1'b0);
                    idle_frames++;
                end
            end
            dccpg_pkg::CMD_START: gen_on = 1'b1;
            dccpg_pkg::CMD_STOP:  gen_on = 1'b0;
            dccpg_pkg::CMD_RESET: begin
                gen_bytes = dccpg_pkg::RESET_BYTES;
                gen_ext   = 1'b0;
                loads++;
            end
            dccpg_pkg::CMD_SHORT: begin
                gen_bytes = {8'hFF, c.address ^ c.data0, c.data0, c.address};
                gen_ext   = 1'b0;
                loads++;
            end
            dccpg_pkg::CMD_EXT: begin
                gen_bytes = {c.address ^ c.data0 ^ c.data1, c.data1, c.data0, c.address};
                gen_ext   = 1'b1;
                loads++;
            end
            default: begin
                rearm = 1'b0;
                ignored_cmds++;
            end
        endcase
        if (rearm) begin
            gen_repeats_left = gen_repeat_count;
            gen_pending      = 1'b1;
        end
    endfunction

    // sample both channels, check symbols, advance the prediction
    always @(posedge aclk) begin
        line_sym_t want;
        s_taken = (aresetn === 1'b1) && (s_tvalid === 1'b1) && (s_tready === 1'b1);
        m_taken = (aresetn === 1'b1) && (m_tvalid === 1'b1) && (m_tready === 1'b1);
        if (m_taken) begin
            if (line_syms_due.size() == 0) begin
                flag_mismatch($sformatf("symbol %0d with nothing expected", m_tdata[2:0]));
            end else begin
                want = line_syms_due.pop_front();
                if (m_tdata[2:0] !== want.sym)
                    flag_mismatch($sformatf("symbol %0d: got %0d, want %0d",
                                            syms_checked, m_tdata[2:0], want.sym));
                if (m_tdata[3] !== want.gate)
                    flag_mismatch($sformatf("symbol %0d: cutout_gate %b, want %b",
                                            syms_checked, m_tdata[3], want.gate));
                if (m_tdata[4] !== want.te)
                    flag_mismatch($sformatf("symbol %0d: track_enable %b, want %b",
                                            syms_checked, m_tdata[4], want.te));
                if (m_tlast !== want.last)
                    flag_mismatch($sformatf("symbol %0d: last %b, want %b",
                                            syms_checked, m_tlast, want.last));
                if (want.last)
                    frames_checked++;
                syms_checked++;
            end
        end
        if (s_taken) begin
            run_command(dcc_cmd_t'(s_tdata[26:0]));
            items_taken++;
        end
        if (s_taken || m_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_MAX) begin
            $display("watchdog: %0d cycles without a transfer", QUIET_MAX);
            $display("dcc_packet_generator_unit_tb: FAIL");
            $finish;
        end
    end

    // sender: bursts of items with random gaps, some stretches gap free
    always @(negedge aclk) begin
        if (!s_tvalid || s_taken) begin
            if (burst_left == 0) begin
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                burst_left = $urandom_range(1, 24);
            end
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                s_tdata  <= {5'd0, cmd_queue.pop_front()};
                s_tvalid <= 1'b1;
                burst_left--;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: rotate between always ready, scattered stalls, long stalls, toggling
    always @(negedge aclk) begin
        rx_cycle++;
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_cycle[10:9])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                2'd2: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(1, 12);
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
                default: m_tready <= rx_cycle[0];
            endcase
        end
    end

    function automatic dcc_cmd_t make_cmd(logic [2:0] op, logic [7:0] a, logic [7:0] d0,
                                          logic [7:0] d1);
        dcc_cmd_t c;
        c.cmd     = op;
        c.address = a;
        c.data0   = d0;
        c.data1   = d1;
        return c;
    endfunction

    function automatic dcc_cmd_t random_cmd(logic [2:0] op);
        return make_cmd(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
    endfunction

    // mostly slots with packet loads sprinkled in; stops, restarts and noise are rarer
    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58)      return dccpg_pkg::CMD_SLOT;
        else if (r < 68) return dccpg_pkg::CMD_SHORT;
        else if (r < 78) return dccpg_pkg::CMD_EXT;
        else if (r < 83) return dccpg_pkg::CMD_RESET;
        else if (r < 89) return dccpg_pkg::CMD_START;
        else if (r < 93) return dccpg_pkg::CMD_STOP;
        else if (r < 96) return CMD_SPARE6;
        else             return CMD_SPARE7;
    endfunction

    task automatic send(input dcc_cmd_t c);
        cmd_queue.push_back(c);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || line_syms_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_repeat_count(input logic [7:0] v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en        <= 1'b0;
        gen_repeat_count = v;
        settings_tried++;
    endtask

    initial begin
        logic [7:0] rpt_plan[5];
        int         len_plan[5];
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = 8'd0;
        s_tvalid         = 1'b0;
        s_tdata          = 32'd0;
        m_tready         = 1'b0;
        gen_on           = 1'b0;
        gen_pending      = 1'b0;
        gen_ext          = 1'b0;
        gen_repeats_left = 8'd0;
        gen_repeat_count = dccpg_pkg::REPEAT_RESET;
        gen_bytes        = dccpg_pkg::IDLE_BYTES;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset repeat count: silent slot, ignored codes, then four packet frames and an idle frame
        send(random_cmd(dccpg_pkg::CMD_SLOT));
        send(random_cmd(CMD_SPARE6));
        send(random_cmd(CMD_SPARE7));
        send(random_cmd(dccpg_pkg::CMD_START));
        repeat (5) send(random_cmd(dccpg_pkg::CMD_SLOT));
        wait_drained();

        set_repeat_count(8'd0);
        send(random_cmd(dccpg_pkg::CMD_RESET));
        send(random_cmd(dccpg_pkg::CMD_SLOT));
        send(make_cmd(dccpg_pkg::CMD_SHORT, 8'hFF, 8'h00, 8'hA5));
        send(random_cmd(dccpg_pkg::CMD_SLOT));
        send(make_cmd(dccpg_pkg::CMD_SHORT, 8'h00, 8'hFF, 8'h5A));
        send(random_cmd(dccpg_pkg::CMD_SLOT));
        send(make_cmd(dccpg_pkg::CMD_EXT, 8'hFF, 8'hFF, 8'hFF));
        send(random_cmd(dccpg_pkg::CMD_SLOT));
        send(make_cmd(dccpg_pkg::CMD_EXT, 8'h00, 8'h00, 8'h00));
        send(random_cmd(dccpg_pkg::CMD_SLOT));
        send(random_cmd(dccpg_pkg::CMD_SLOT));
        // a start after the idle frame resends the extended bytes in the short layout
        send(random_cmd(dccpg_pkg::CMD_START));
        send(random_cmd(dccpg_pkg::CMD_SLOT));
        send(random_cmd(dccpg_pkg::CMD_STOP));
        send(random_cmd(dccpg_pkg::CMD_SLOT));
        send(random_cmd(dccpg_pkg::CMD_START));
        send(random_cmd(dccpg_pkg::CMD_SLOT));
        wait_drained();

        rpt_plan = '{8'd1, 8'd255, 8'($urandom_range(4, 254)), 8'd0, 8'd2};
        len_plan = '{60, 30, 70, 70, 70};
        for (int ph = 0; ph < 5; ph++) begin
            set_repeat_count(rpt_plan[ph]);
            send(random_cmd(dccpg_pkg::CMD_START));
            for (int n = 1; n < len_plan[ph]; n++) begin
                // in the third phase, hold the sender once mid-phase until the line has gone quiet
                if (ph == 2 && n == len_plan[ph] / 2)
                    wait_drained();
                send(random_cmd(pick_op()));
            end
            wait_drained();
        end

        $display("%0d items taken: %0d packet loads, %0d slots silenced, %0d ignored codes",
                 items_taken, loads, muted_slots, ignored_cmds);
        $display("%0d symbols in %0d frames (%0d packet, %0d idle), %0d repeat_count settings",
                 syms_checked, frames_checked, packet_frames, idle_frames, settings_tried);
        if (mism_count == 0)
            $display("dcc_packet_generator_unit_tb: PASS");
        else
            $display("dcc_packet_generator_unit_tb: FAIL");
        $finish;
    end

endmodule
